>>> rtl/core/image_resize_sampler_core_defines.svh
// ---------------------------------------------------------------------------
// Image resize sampler assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during rst.
// ---------------------------------------------------------------------------
`ifndef IMAGE_RESIZE_SAMPLER_CORE_DEFINES_SVH
`define IMAGE_RESIZE_SAMPLER_CORE_DEFINES_SVH

// Same-cycle implication
`define IRS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define IRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/irs_pkg.sv
// ---------------------------------------------------------------------------
// Image resize sampler package
// Store geometry, fixed-point constants and command/register codes.
// ---------------------------------------------------------------------------
package irs_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int CHANNELS   = 4;

  localparam int PIX_W   = 16;
  localparam int COL_W   = 8;
  localparam int ROW_W   = 8;
  localparam int CHAN_W  = 2;
  localparam int STEP_W  = 25;
  localparam int SIZE_W  = 9;
  localparam int FRAC_W  = 17;
  localparam int PROD_W  = COL_W + 1 + STEP_W;

  // Four banks split by row and column parity
  localparam int BANKS     = 4;
  localparam int BANK_AW   = CHAN_W + (ROW_W - 1) + (COL_W - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;

  localparam logic [FRAC_W:0] FRAC_ONE = 18'd131072;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_REQUEST = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_SOURCE_WIDTH    = 3'd0,
    CFG_SOURCE_HEIGHT   = 3'd1,
    CFG_HORIZONTAL_STEP = 3'd2,
    CFG_VERTICAL_STEP   = 3'd3,
    CFG_SAMPLING_MODE   = 3'd4
  } cfg_index_t;

endpackage

>>> rtl/core/image_resize_sampler_core.sv
// ---------------------------------------------------------------------------
// Image resize sampler core
// Nearest-neighbour and bilinear resampler over a channel-planar source store.
//
// Load requests write one source pixel; sample requests return one resampled
// pixel. The block takes one request per clock while in_stall is low, and a
// sample result passes the stage chain into the pixel_out register. The rate is set
// by the source store: it is split into four single-port banks by row and
// column parity, so the four neighbours of a bilinear sample are all read in
// the same cycle, and loads write the banks in that same pipeline stage so
// reads and writes stay in request order. Results leave through an output
// register; back-pressure on out_stall passes back through the stage chain in
// the same cycle, so bubbles are squeezed out before in_stall rises. The store
// needs no clearing after reset; configuration writes are always taken and
// belong in idle periods.
// ---------------------------------------------------------------------------
module image_resize_sampler_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             cmd,
  input  logic [irs_pkg::COL_W-1:0]        column,
  input  logic [irs_pkg::ROW_W-1:0]        row,
  input  logic [irs_pkg::CHAN_W-1:0]       channel,
  input  logic [irs_pkg::PIX_W-1:0]        pixel_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [irs_pkg::PIX_W-1:0]        pixel_out,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [2:0]                       cfg_index,
  input  logic [irs_pkg::STEP_W-1:0]       cfg_data
);

  typedef struct packed {
    logic [7:0]                   lo;
    logic [7:0]                   hi;
    logic [irs_pkg::FRAC_W-1:0]   frac;
  } axis_t;

  function automatic logic [7:0] clamp_idx(input logic signed [18:0] v,
                                           input logic [7:0] lim);
    logic [7:0] r;
    if (v < 19'sd0) begin
      r = 8'd0;
    end else if (v > $signed({11'b0, lim})) begin
      r = lim;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  // Source coordinate in units of 2^-17 is prod - 0.5; split into the two
  // neighbour indices and the fraction towards the upper one.
  function automatic axis_t map_axis(input logic [irs_pkg::PROD_W-1:0] prod,
                                     input logic bilinear,
                                     input logic [7:0] lim);
    logic signed [34:0] c;
    logic signed [34:0] cr;
    logic signed [17:0] fl;
    logic signed [17:0] rn;
    logic signed [17:0] base;
    logic signed [18:0] b0;
    logic signed [18:0] b1;
    axis_t              a;
    c    = $signed({1'b0, prod}) - 35'sd65536;
    cr   = c + 35'sd65536;
    fl   = c[34:17];
    rn   = c[34] ? 18'sd0 : cr[34:17];
    base = bilinear ? fl : rn;
    b0   = {base[17], base};
    // nearest neighbour reads the one rounded tap on both sides
    b1   = bilinear ? b0 + 19'sd1 : b0;
    a.lo   = clamp_idx(b0, lim);
    a.hi   = clamp_idx(b1, lim);
    a.frac = bilinear ? c[16:0] : '0;
    return a;
  endfunction

  // Configuration registers
  logic [irs_pkg::SIZE_W-1:0] source_width;
  logic [irs_pkg::SIZE_W-1:0] source_height;
  logic [irs_pkg::STEP_W-1:0] horizontal_step;
  logic [irs_pkg::STEP_W-1:0] vertical_step;
  logic                       sampling_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width    <= 9'd1;
      source_height   <= 9'd1;
      horizontal_step <= 25'd65536;
      vertical_step   <= 25'd65536;
      sampling_mode   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        irs_pkg::CFG_SOURCE_WIDTH:    source_width    <= cfg_data[irs_pkg::SIZE_W-1:0];
        irs_pkg::CFG_SOURCE_HEIGHT:   source_height   <= cfg_data[irs_pkg::SIZE_W-1:0];
        irs_pkg::CFG_HORIZONTAL_STEP: horizontal_step <= cfg_data;
        irs_pkg::CFG_VERTICAL_STEP:   vertical_step   <= cfg_data;
        irs_pkg::CFG_SAMPLING_MODE:   sampling_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Last valid index on each axis; zero acts as one, oversize saturates
  logic [7:0] width_lim;
  logic [7:0] height_lim;

  always_comb begin
    if (source_width == '0) begin
      width_lim = 8'd0;
    end else if (source_width > 9'(irs_pkg::MAX_WIDTH)) begin
      width_lim = 8'(irs_pkg::MAX_WIDTH - 1);
    end else begin
      width_lim = 8'(source_width - 9'd1);
    end
    if (source_height == '0) begin
      height_lim = 8'd0;
    end else if (source_height > 9'(irs_pkg::MAX_HEIGHT)) begin
      height_lim = 8'(irs_pkg::MAX_HEIGHT - 1);
    end else begin
      height_lim = 8'(source_height - 9'd1);
    end
  end

  // Stage handshake: a stage moves on when it is empty or its successor moves
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  assign rdy6 = !s6_valid || !out_stall;
  assign rdy5 = !s5_valid || rdy6;
  assign rdy4 = !s4_valid || rdy5;
  assign rdy3 = !s3_valid || rdy4;
  assign rdy2 = !s2_valid || rdy3;
  assign rdy1 = !s1_valid || rdy2;

  assign in_stall  = !rdy1;
  assign out_valid = s6_valid;

  // Stage 1: coordinate products (2*dst+1)*step
  logic                          s1_req;
  logic [irs_pkg::COL_W-1:0]     s1_col;
  logic [irs_pkg::ROW_W-1:0]     s1_row;
  logic [irs_pkg::CHAN_W-1:0]    s1_ch;
  logic [irs_pkg::PIX_W-1:0]     s1_pix;
  logic [irs_pkg::PROD_W-1:0]    s1_px;
  logic [irs_pkg::PROD_W-1:0]    s1_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rdy1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_req <= (cmd == irs_pkg::CMD_REQUEST);
      s1_col <= column;
      s1_row <= row;
      s1_ch  <= channel;
      s1_pix <= pixel_in;
      s1_px  <= irs_pkg::PROD_W'({column, 1'b1}) * irs_pkg::PROD_W'(horizontal_step);
      s1_py  <= irs_pkg::PROD_W'({row, 1'b1}) * irs_pkg::PROD_W'(vertical_step);
    end
  end

  // Stage 2: neighbour indices and fractions; loads carry their position
  axis_t ax;
  axis_t ay;

  assign ax = map_axis(s1_px, sampling_mode, width_lim);
  assign ay = map_axis(s1_py, sampling_mode, height_lim);

  logic                          s2_req;
  logic                          s2_chan_ok;
  logic [irs_pkg::CHAN_W-1:0]    s2_ch;
  logic [7:0]                    s2_xa, s2_xb, s2_ya, s2_yb;
  logic [irs_pkg::FRAC_W-1:0]    s2_fx, s2_fy;
  logic [irs_pkg::PIX_W-1:0]     s2_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (rdy2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_req     <= s1_req;
      s2_ch      <= s1_ch;
      s2_chan_ok <= ({1'b0, s1_ch} < 3'(irs_pkg::CHANNELS));
      s2_pix     <= s1_pix;
      s2_xa      <= s1_req ? ax.lo : s1_col;
      s2_xb      <= s1_req ? ax.hi : s1_col;
      s2_ya      <= s1_req ? ay.lo : s1_row;
      s2_yb      <= s1_req ? ay.hi : s1_row;
      s2_fx      <= ax.frac;
      s2_fy      <= ay.frac;
    end
  end

  // Source store: four parity banks. Reads and loads share this one stage, so
  // they happen in request order and need no forwarding.
  logic                          bank_re;
  logic [irs_pkg::BANKS-1:0]     bank_we;
  logic [irs_pkg::BANKS-1:0][irs_pkg::PIX_W-1:0] bank_q;

  assign bank_re = s2_valid && s2_req && rdy3;

  for (genvar b = 0; b < irs_pkg::BANKS; b++) begin : g_bank
    localparam logic RP = 1'((b >> 1) & 1);
    localparam logic CP = 1'(b & 1);

    logic [irs_pkg::PIX_W-1:0]   mem [irs_pkg::BANK_DEPTH];
    logic [irs_pkg::PIX_W-1:0]   q;
    logic [7:0]                  row_sel;
    logic [7:0]                  col_sel;
    logic [irs_pkg::BANK_AW-1:0] addr;

    assign row_sel = (s2_ya[0] == RP) ? s2_ya : s2_yb;
    assign col_sel = (s2_xa[0] == CP) ? s2_xa : s2_xb;
    assign addr    = {s2_ch, row_sel[7:1], col_sel[7:1]};
    assign bank_we[b] = s2_valid && !s2_req && s2_chan_ok && rdy3 &&
                        (s2_ya[0] == RP) && (s2_xa[0] == CP);

    always_ff @(posedge clk) begin
      if (bank_we[b]) begin
        mem[addr] <= s2_pix;
      end
      if (bank_re) begin
        q <= mem[addr];
      end
    end

    assign bank_q[b] = q;
  end

  // Stage 3: pick the four neighbours, blend along x
  logic                          s3_chan_ok;
  logic                          s3_xa0, s3_xb0, s3_ya0, s3_yb0;
  logic [irs_pkg::FRAC_W-1:0]    s3_fx, s3_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (rdy3) begin
      s3_valid <= s2_valid && s2_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_chan_ok <= s2_chan_ok;
      s3_xa0     <= s2_xa[0];
      s3_xb0     <= s2_xb[0];
      s3_ya0     <= s2_ya[0];
      s3_yb0     <= s2_yb[0];
      s3_fx      <= s2_fx;
      s3_fy      <= s2_fy;
    end
  end

  logic [irs_pkg::PIX_W-1:0]  p_aa, p_ab, p_ba, p_bb;
  logic [irs_pkg::FRAC_W:0]   gx;
  logic [33:0]                top_next, bot_next;

  always_comb begin
    p_aa = bank_q[{s3_ya0, s3_xa0}];
    p_ab = bank_q[{s3_ya0, s3_xb0}];
    p_ba = bank_q[{s3_yb0, s3_xa0}];
    p_bb = bank_q[{s3_yb0, s3_xb0}];
    gx   = irs_pkg::FRAC_ONE - {1'b0, s3_fx};
    top_next = 34'(p_aa) * 34'(gx) + 34'(p_ab) * 34'(s3_fx);
    bot_next = 34'(p_ba) * 34'(gx) + 34'(p_bb) * 34'(s3_fx);
  end

  // Stage 4: horizontal blends
  logic                        s4_chan_ok;
  logic [33:0]                 s4_top, s4_bot;
  logic [irs_pkg::FRAC_W-1:0]  s4_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (rdy4) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_chan_ok <= s3_chan_ok;
      s4_top     <= top_next;
      s4_bot     <= bot_next;
      s4_fy      <= s3_fy;
    end
  end

  // Stage 5: weight along y
  logic [irs_pkg::FRAC_W:0] gy;
  logic                     s5_chan_ok;
  logic [51:0]              s5_top, s5_bot;

  assign gy = irs_pkg::FRAC_ONE - {1'b0, s4_fy};

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (rdy5) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_chan_ok <= s4_chan_ok;
      s5_top     <= 52'(s4_top) * 52'(gy);
      s5_bot     <= 52'(s4_bot) * 52'(s4_fy);
    end
  end

  // Stage 6: sum, round to nearest, saturate into the output register
  logic [51:0]              sum_rnd;
  logic [17:0]              res_wide;
  logic [irs_pkg::PIX_W-1:0] res_sat;

  always_comb begin
    sum_rnd  = s5_top + s5_bot + 52'h2_0000_0000;
    res_wide = sum_rnd[51:34];
    res_sat  = (|res_wide[17:16]) ? '1 : res_wide[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (rdy6) begin
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      pixel_out <= s5_chan_ok ? res_sat : '0;
    end
  end

endmodule

>>> rtl/core/irs_checker.sv
// ---------------------------------------------------------------------------
// Image resize sampler port checker
// Watches the top-level handshakes and flow control over time.
// ---------------------------------------------------------------------------
`include "image_resize_sampler_core_defines.svh"

module irs_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [irs_pkg::PIX_W-1:0]  pixel_out,
  input logic                       cfg_valid,
  input logic                       cfg_ready
);

  // Output request must hold while stalled
  `IRS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")
  `IRS_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(pixel_out), "result changed under stall")
  // An empty output register never back-pressures the input side
  `IRS_ASSERT_IMPL(a_no_stall_when_empty, !out_valid, !in_stall, "input stalled with no result waiting")
  // Reset leaves no result behind
  `IRS_ASSERT_IMPL(a_reset_clears, $past(rst), !out_valid, "result present straight after reset")
  `IRS_ASSERT_IMPL(a_cfg_taken, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind image_resize_sampler_core irs_checker u_irs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .pixel_out (pixel_out),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
